>>> src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and UTF-8 helpers shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STR,
    PH_ESC,
    PH_UHEX,
    PH_AFTER_HIGH,
    PH_HIGH_BSL,
    PH_HIGH_UHEX
  } phase_e;

  // kind of the second result group of a command
  typedef enum logic [1:0] {
    K_NONE,
    K_RAW,
    K_CODE,
    K_STAT
  } kind_e;

  localparam logic [2:0] ST_BYTE       = 3'd0;
  localparam logic [2:0] ST_CLOSED     = 3'd1;
  localparam logic [2:0] ST_EXP_QUOTE  = 3'd2;
  localparam logic [2:0] ST_UNTERM     = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;
  localparam logic [2:0] ST_BAD_UNI    = 3'd5;
  localparam logic [2:0] ST_UNSUP_ESC  = 3'd6;
  localparam logic [2:0] ST_CTRL       = 3'd7;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CTRL_LIM = 8'h20;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

  // one accepted item's worth of results: optional code point, then one group
  typedef struct packed {
    logic        a_vld;
    logic [20:0] a_cp;
    kind_e       b_kind;
    logic [15:0] b_data;
  } cmd_t;

  // number of UTF-8 bytes minus one
  function automatic logic [1:0] utf8_len(logic [20:0] cp);
    logic [1:0] l;
    if (cp <= 21'h7F) begin
      l = 2'd0;
    end else if (cp <= 21'h7FF) begin
      l = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      l = 2'd2;
    end else begin
      l = 2'd3;
    end
    return l;
  endfunction

  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] len, logic [1:0] k);
    logic [7:0] r;
    r = 8'h00;
    case (len)
      2'd0: r = {1'b0, cp[6:0]};
      2'd1: begin
        r = (k == 2'd0) ? (UTF8_LEAD2 | {3'b000, cp[10:6]}) : (UTF8_CONT | {2'b00, cp[5:0]});
      end
      2'd2: begin
        case (k)
          2'd0:    r = UTF8_LEAD3 | {4'h0, cp[15:12]};
          2'd1:    r = UTF8_CONT | {2'b00, cp[11:6]};
          default: r = UTF8_CONT | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    r = UTF8_LEAD4 | {5'h00, cp[20:18]};
          2'd1:    r = UTF8_CONT | {2'b00, cp[17:12]};
          2'd2:    r = UTF8_CONT | {2'b00, cp[11:6]};
          default: r = UTF8_CONT | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

>>> src/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Source byte channel: one source byte or an end mark per beat.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       at_end;

  modport source (output valid, output data_byte, output at_end, input ready);
  modport sink (input valid, input data_byte, input at_end, output ready);
endinterface

>>> src/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Decoded result channel: one byte or status per beat.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

>>> src/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string unescaper with UTF-8 output.
//
// in_i  : one source byte (or an end mark) per beat, valid/ready.
// out_o : one decoded byte or status per beat; last marks the final beat
//         caused by an input beat. Input beats that cause nothing (opening
//         quote, backslash, hex digits) produce no output beat.
// Each command is registered in the command queue, then in the sequencer.
// Throughput: one input beat per cycle while each item yields one result.
//   An item yielding k beats (up to 6) holds the result sequencer until
//   all k are taken; the two-entry command queue absorbs that and stalls in_i.ready.
// Reset clears the parser to idle (awaiting the opening quote), empties the
// queue and drops any pending output. When out_o.ready is low the current
// beat holds; the parser keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input logic clk_i,
  input logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic          push, full, pop, q_vld;
  jsu_pkg::cmd_t push_cmd, head_cmd;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .data_byte_i (in_i.data_byte),
    .at_end_i    (in_i.at_end),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  jsu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (q_vld),
    .data_o (head_cmd)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_data_i    (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .status_o    (out_o.status),
    .last_o      (out_o.last)
  );

endmodule

>>> src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser state machine: takes one source beat a cycle while the queue is not
// full and emits a command describing the results that beat causes.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          at_end_i,
  input  logic          full_i,
  output logic          push_o,
  output jsu_pkg::cmd_t cmd_o
);

  jsu_pkg::phase_e phase_q, phase_d;
  logic [15:0]     hex_q, hex_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [15:0]     high_q, high_d;

  logic            accept;
  logic [7:0]      c;
  logic            eoi;

  jsu_pkg::kind_e  sb_kind, esc_kind;
  logic [15:0]     sb_data, esc_data;
  jsu_pkg::phase_e sb_phase, esc_phase;

  logic [3:0]      hv;
  logic            hok;
  logic [15:0]     v;
  logic [20:0]     joined;
  jsu_pkg::cmd_t   cmd;

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign c          = data_byte_i;
  assign eoi        = at_end_i;

  // plain string byte
  always_comb begin
    sb_kind  = jsu_pkg::K_RAW;
    sb_data  = {8'h00, c};
    sb_phase = jsu_pkg::PH_STR;
    if (eoi) begin
      sb_kind  = jsu_pkg::K_STAT;
      sb_data  = {13'h0000, jsu_pkg::ST_UNTERM};
      sb_phase = jsu_pkg::PH_IDLE;
    end else if (c == jsu_pkg::CH_QUOTE) begin
      sb_kind  = jsu_pkg::K_STAT;
      sb_data  = {13'h0000, jsu_pkg::ST_CLOSED};
      sb_phase = jsu_pkg::PH_IDLE;
    end else if (c == jsu_pkg::CH_BSL) begin
      sb_kind  = jsu_pkg::K_NONE;
      sb_phase = jsu_pkg::PH_ESC;
    end else if (c < jsu_pkg::CTRL_LIM) begin
      sb_kind  = jsu_pkg::K_STAT;
      sb_data  = {13'h0000, jsu_pkg::ST_CTRL};
      sb_phase = jsu_pkg::PH_IDLE;
    end
  end

  // byte after a backslash
  always_comb begin
    esc_kind  = jsu_pkg::K_RAW;
    esc_data  = {8'h00, c};
    esc_phase = jsu_pkg::PH_STR;
    if (eoi) begin
      esc_kind  = jsu_pkg::K_STAT;
      esc_data  = {13'h0000, jsu_pkg::ST_INCOMPLETE};
      esc_phase = jsu_pkg::PH_IDLE;
    end else begin
      case (c)
        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: esc_data = {8'h00, c};
        jsu_pkg::CH_B: esc_data = 16'h0008;
        jsu_pkg::CH_F: esc_data = 16'h000C;
        jsu_pkg::CH_N: esc_data = 16'h000A;
        jsu_pkg::CH_R: esc_data = 16'h000D;
        jsu_pkg::CH_T: esc_data = 16'h0009;
        jsu_pkg::CH_U: begin
          esc_kind  = jsu_pkg::K_NONE;
          esc_phase = jsu_pkg::PH_UHEX;
        end
        default: begin
          esc_kind  = jsu_pkg::K_STAT;
          esc_data  = {13'h0000, jsu_pkg::ST_UNSUP_ESC};
          esc_phase = jsu_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    hok = 1'b1;
    hv  = 4'h0;
    if (c inside {[8'h30:8'h39]}) begin
      hv = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hv = c[3:0] + 4'd9;
    end else begin
      hok = 1'b0;
    end
    if (eoi) begin
      hok = 1'b0;
    end
  end

  assign v      = {hex_q[11:0], hv};
  assign joined = jsu_pkg::SUPP_BASE + {1'b0, high_q[9:0], v[9:0]};

  always_comb begin
    phase_d = phase_q;
    hex_d   = hex_q;
    cnt_d   = cnt_q;
    high_d  = high_q;
    cmd     = '0;
    case (phase_q)
      jsu_pkg::PH_STR: begin
        cmd.b_kind = sb_kind;
        cmd.b_data = sb_data;
        phase_d    = sb_phase;
      end
      jsu_pkg::PH_ESC: begin
        cmd.b_kind = esc_kind;
        cmd.b_data = esc_data;
        phase_d    = esc_phase;
        hex_d      = '0;
        cnt_d      = '0;
      end
      jsu_pkg::PH_UHEX, jsu_pkg::PH_HIGH_UHEX: begin
        if (!hok) begin
          cmd.a_vld  = (phase_q == jsu_pkg::PH_HIGH_UHEX);
          cmd.a_cp   = {5'h00, high_q};
          cmd.b_kind = jsu_pkg::K_STAT;
          cmd.b_data = {13'h0000, jsu_pkg::ST_BAD_UNI};
          phase_d    = jsu_pkg::PH_IDLE;
        end else if (cnt_q != 2'd3) begin
          hex_d = v;
          cnt_d = cnt_q + 2'd1;
        end else begin
          hex_d = '0;
          cnt_d = '0;
          if (phase_q == jsu_pkg::PH_HIGH_UHEX && v >= jsu_pkg::LOW_MIN &&
              v <= jsu_pkg::LOW_MAX) begin
            cmd.a_vld = 1'b1;
            cmd.a_cp  = joined;
            phase_d   = jsu_pkg::PH_STR;
          end else begin
            cmd.a_vld = (phase_q == jsu_pkg::PH_HIGH_UHEX);
            cmd.a_cp  = {5'h00, high_q};
            if (v >= jsu_pkg::HIGH_MIN && v <= jsu_pkg::HIGH_MAX) begin
              high_d  = v;
              phase_d = jsu_pkg::PH_AFTER_HIGH;
            end else begin
              cmd.b_kind = jsu_pkg::K_CODE;
              cmd.b_data = v;
              phase_d    = jsu_pkg::PH_STR;
            end
          end
        end
      end
      jsu_pkg::PH_AFTER_HIGH: begin
        if (!eoi && c == jsu_pkg::CH_BSL) begin
          phase_d = jsu_pkg::PH_HIGH_BSL;
        end else begin
          cmd.a_vld  = 1'b1;
          cmd.a_cp   = {5'h00, high_q};
          cmd.b_kind = sb_kind;
          cmd.b_data = sb_data;
          phase_d    = sb_phase;
        end
      end
      jsu_pkg::PH_HIGH_BSL: begin
        hex_d = '0;
        cnt_d = '0;
        if (!eoi && c == jsu_pkg::CH_U) begin
          phase_d = jsu_pkg::PH_HIGH_UHEX;
        end else begin
          cmd.a_vld  = 1'b1;
          cmd.a_cp   = {5'h00, high_q};
          cmd.b_kind = esc_kind;
          cmd.b_data = esc_data;
          phase_d    = esc_phase;
        end
      end
      default: begin
        if (!eoi && c == jsu_pkg::CH_QUOTE) begin
          phase_d = jsu_pkg::PH_STR;
        end else begin
          cmd.b_kind = jsu_pkg::K_STAT;
          cmd.b_data = {13'h0000, jsu_pkg::ST_EXP_QUOTE};
          phase_d    = jsu_pkg::PH_IDLE;
        end
      end
    endcase
  end

  assign push_o = accept && (cmd.a_vld || cmd.b_kind != jsu_pkg::K_NONE);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_IDLE;
      cnt_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hex_q  <= hex_d;
      high_q <= high_d;
    end
  end

endmodule

>>> src/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Two-entry command queue between parser and result sequencer.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          vld_o,
  output jsu_pkg::cmd_t data_o
);

  localparam int unsigned Depth = 2;

  jsu_pkg::cmd_t mem_q [Depth];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == 2'(Depth));
  assign vld_o   = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Result sequencer: expands one command into UTF-8, raw and status beats.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_vld_i,
  input  jsu_pkg::cmd_t q_data_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic [2:0]    status_o,
  output logic          last_o
);

  jsu_pkg::cmd_t cmd_q, cmd_d;
  logic          cmd_vld_q, cmd_vld_d;
  logic          seg_q, seg_d;
  logic [1:0]    idx_q, idx_d;

  logic [1:0]    len_a, len_b, seg_len;
  logic          seg_end, beat_last, fire;

  assign len_a = jsu_pkg::utf8_len(cmd_q.a_cp);
  assign len_b = jsu_pkg::utf8_len({5'h00, cmd_q.b_data});

  always_comb begin
    seg_len    = 2'd0;
    out_byte_o = 8'h00;
    status_o   = jsu_pkg::ST_BYTE;
    if (!seg_q) begin
      seg_len    = len_a;
      out_byte_o = jsu_pkg::utf8_byte(cmd_q.a_cp, len_a, idx_q);
    end else begin
      case (cmd_q.b_kind)
        jsu_pkg::K_RAW: out_byte_o = cmd_q.b_data[7:0];
        jsu_pkg::K_CODE: begin
          seg_len    = len_b;
          out_byte_o = jsu_pkg::utf8_byte({5'h00, cmd_q.b_data}, len_b, idx_q);
        end
        jsu_pkg::K_STAT: status_o = cmd_q.b_data[2:0];
        default: out_byte_o = 8'h00;
      endcase
    end
  end

  assign seg_end     = (idx_q == seg_len);
  assign beat_last   = seg_end && (seg_q || cmd_q.b_kind == jsu_pkg::K_NONE);
  assign out_valid_o = cmd_vld_q;
  assign last_o      = beat_last;
  assign fire        = cmd_vld_q && out_ready_i;
  assign pop_o       = q_vld_i && (!cmd_vld_q || (fire && beat_last));

  always_comb begin
    cmd_d     = cmd_q;
    cmd_vld_d = cmd_vld_q;
    seg_d     = seg_q;
    idx_d     = idx_q;
    if (pop_o) begin
      cmd_d     = q_data_i;
      cmd_vld_d = 1'b1;
      seg_d     = !q_data_i.a_vld;
      idx_d     = '0;
    end else if (fire) begin
      if (beat_last) begin
        cmd_vld_d = 1'b0;
      end else if (seg_end) begin
        seg_d = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      seg_q     <= 1'b0;
      idx_q     <= '0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
      seg_q     <= seg_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  a_code_seg_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_vld_q && !seg_q) |-> cmd_q.a_vld)
    else $error("code segment active without a code point");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_vld_q && status_o != jsu_pkg::ST_BYTE) |-> last_o)
    else $error("status beat not last of its item");

  a_more_beats_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !beat_last) |=> cmd_vld_q)
    else $error("command dropped before its last beat");

endmodule

>>> tb/jsu_decode_check.sv
// ----------------------------------------------------------------------------
// jsu_decode_check
// Watches both channels of the JSON string unescaper. Each accepted source
// beat runs through a cycle-free model of the parser, which queues the result
// beats it should cause. Each accepted result beat is compared field by field
// against the oldest queued one.
// ----------------------------------------------------------------------------
module jsu_decode_check (
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if    src_i,
  jsu_out_if   dec_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   beats_o,
  output int   results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } dec_beat_t;

  jsu_pkg::phase_e ph = jsu_pkg::PH_IDLE;
  logic [15:0]     acc = '0;
  logic [1:0]      nd = '0;
  logic [15:0]     hi = '0;

  dec_beat_t   item_q[$];
  dec_beat_t   expect_q[$];

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'd16;
  endfunction

  task automatic put_beat(input logic [7:0] b, input logic [2:0] st);
    dec_beat_t nb;
    nb.out_byte = (st == jsu_pkg::ST_BYTE) ? b : 8'h00;
    nb.status   = st;
    nb.last     = 1'b0;
    item_q.insert(item_q.size(), nb);
  endtask

  task automatic abort_to_idle(input logic [2:0] st);
    put_beat(8'h00, st);
    ph  = jsu_pkg::PH_IDLE;
    acc = '0;
    nd  = '0;
    hi  = '0;
  endtask

  task automatic put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_beat(cp[7:0], jsu_pkg::ST_BYTE);
    end else if (cp <= 21'h7FF) begin
      put_beat({3'b110, cp[10:6]}, jsu_pkg::ST_BYTE);
      put_beat({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
    end else if (cp <= 21'hFFFF) begin
      put_beat({4'b1110, cp[15:12]}, jsu_pkg::ST_BYTE);
      put_beat({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE);
      put_beat({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
    end else begin
      put_beat({5'b11110, cp[20:18]}, jsu_pkg::ST_BYTE);
      put_beat({2'b10, cp[17:12]}, jsu_pkg::ST_BYTE);
      put_beat({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE);
      put_beat({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
    end
  endtask

  // flush a held high surrogate as a lone code
  task automatic flush_high();
    put_utf8({5'b0, hi});
    hi = '0;
  endtask

  task automatic take_code(input logic [15:0] cp);
    if (cp >= jsu_pkg::HIGH_MIN && cp <= jsu_pkg::HIGH_MAX) begin
      hi = cp;
      ph = jsu_pkg::PH_AFTER_HIGH;
    end else begin
      put_utf8({5'b0, cp});
      ph = jsu_pkg::PH_STR;
    end
  endtask

  task automatic string_char(input logic at_end, input logic [7:0] c);
    if (at_end) begin
      abort_to_idle(jsu_pkg::ST_UNTERM);
    end else if (c == jsu_pkg::CH_QUOTE) begin
      put_beat(8'h00, jsu_pkg::ST_CLOSED);
      ph = jsu_pkg::PH_IDLE;
    end else if (c == jsu_pkg::CH_BSL) begin
      ph = jsu_pkg::PH_ESC;
    end else if (c < jsu_pkg::CTRL_LIM) begin
      abort_to_idle(jsu_pkg::ST_CTRL);
    end else begin
      put_beat(c, jsu_pkg::ST_BYTE);
      ph = jsu_pkg::PH_STR;
    end
  endtask

  task automatic escape_char(input logic at_end, input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (at_end) begin
      abort_to_idle(jsu_pkg::ST_INCOMPLETE);
    end else if (c == jsu_pkg::CH_U) begin
      acc = '0;
      nd  = '0;
      ph  = jsu_pkg::PH_UHEX;
    end else if (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL || c == jsu_pkg::CH_SLASH ||
                 c == jsu_pkg::CH_B || c == jsu_pkg::CH_F || c == jsu_pkg::CH_N ||
                 c == jsu_pkg::CH_R || c == jsu_pkg::CH_T) begin
      case (c)
        jsu_pkg::CH_B: v = 8'h08;
        jsu_pkg::CH_F: v = 8'h0C;
        jsu_pkg::CH_N: v = 8'h0A;
        jsu_pkg::CH_R: v = 8'h0D;
        jsu_pkg::CH_T: v = 8'h09;
        default:       v = c;
      endcase
      put_beat(v, jsu_pkg::ST_BYTE);
      ph = jsu_pkg::PH_STR;
    end else begin
      abort_to_idle(jsu_pkg::ST_UNSUP_ESC);
    end
  endtask

  task automatic predict_beat(input logic [7:0] c, input logic at_end);
    logic [4:0]  d;
    logic [15:0] v;
    item_q.delete();
    case (ph)
      jsu_pkg::PH_STR: string_char(at_end, c);
      jsu_pkg::PH_ESC: escape_char(at_end, c);
      jsu_pkg::PH_UHEX, jsu_pkg::PH_HIGH_UHEX: begin
        d = at_end ? 5'd16 : hex_nibble(c);
        if (d[4]) begin
          if (ph == jsu_pkg::PH_HIGH_UHEX) flush_high();
          abort_to_idle(jsu_pkg::ST_BAD_UNI);
        end else begin
          v = {acc[11:0], d[3:0]};
          if (nd < 2'd3) begin
            acc = v;
            nd  = nd + 2'd1;
          end else begin
            acc = '0;
            nd  = '0;
            if (ph == jsu_pkg::PH_HIGH_UHEX && v >= jsu_pkg::LOW_MIN &&
                v <= jsu_pkg::LOW_MAX) begin
              put_utf8(jsu_pkg::SUPP_BASE + {1'b0, hi[9:0], v[9:0]});
              hi = '0;
              ph = jsu_pkg::PH_STR;
            end else begin
              if (ph == jsu_pkg::PH_HIGH_UHEX) flush_high();
              take_code(v);
            end
          end
        end
      end
      jsu_pkg::PH_AFTER_HIGH: begin
        if (!at_end && c == jsu_pkg::CH_BSL) begin
          ph = jsu_pkg::PH_HIGH_BSL;
        end else begin
          flush_high();
          string_char(at_end, c);
        end
      end
      jsu_pkg::PH_HIGH_BSL: begin
        if (!at_end && c == jsu_pkg::CH_U) begin
          acc = '0;
          nd  = '0;
          ph  = jsu_pkg::PH_HIGH_UHEX;
        end else begin
          flush_high();
          escape_char(at_end, c);
        end
      end
      default: begin
        if (!at_end && c == jsu_pkg::CH_QUOTE) begin
          ph  = jsu_pkg::PH_STR;
          acc = '0;
          nd  = '0;
          hi  = '0;
        end else begin
          abort_to_idle(jsu_pkg::ST_EXP_QUOTE);
        end
      end
    endcase
    if (item_q.size() > 0) item_q[item_q.size() - 1].last = 1'b1;
    foreach (item_q[i]) expect_q.insert(expect_q.size(), item_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dec_beat_t want;
    if (!rst_ni) begin
      ph  = jsu_pkg::PH_IDLE;
      acc = '0;
      nd  = '0;
      hi  = '0;
      expect_q.delete();
      pending_o = 0;
    end else begin
      // results first: a result beat can never stem from a same-edge source beat
      if (dec_i.valid && dec_i.ready) begin
        results_o++;
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected result beat: byte=%h status=%0d last=%b",
                   $time, dec_i.out_byte, dec_i.status, dec_i.last);
          fail_count_o++;
        end else begin
          want = expect_q.pop_front();
          if (dec_i.out_byte !== want.out_byte || dec_i.status !== want.status ||
              dec_i.last !== want.last) begin
            $display("%0t: result mismatch: expected byte=%h status=%0d last=%b",
                     $time, want.out_byte, want.status, want.last);
            $display("%0t:                  actual   byte=%h status=%0d last=%b",
                     $time, dec_i.out_byte, dec_i.status, dec_i.last);
            fail_count_o++;
          end
        end
      end
      if (src_i.valid && src_i.ready) begin
        beats_o++;
        predict_beat(src_i.data_byte, src_i.at_end);
      end
      pending_o = expect_q.size();
    end
  end

endmodule

>>> tb/tb_json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// Feeds the unescaper a short directed string, then random JSON strings built
// from plain text, high bytes, escapes, \u codes, surrogate pairs and broken
// endings. The sender runs in bursts, the receiver stalls on its own pattern
// and once holds off long enough to back the block up. Checking is done by
// jsu_decode_check.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       at_end;
  } src_beat_t;

  localparam int RANDOM_BEATS = 500;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 160;

  localparam int CP_ASCII = 0;
  localparam int CP_TWO   = 1;
  localparam int CP_THREE = 2;
  localparam int CP_HIGH  = 3;
  localparam int CP_LOW   = 4;

  logic clk_i;
  logic rst_ni;

  jsu_in_if  src_if ();
  jsu_out_if dec_if ();

  int        fail_count;
  int        pending;
  int        beats;
  int        results;
  int        sent;
  int        strings;
  bit        src_done;
  src_beat_t src_q[$];

  json_string_unescape_utf8 uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (src_if),
    .out_o  (dec_if)
  );

  jsu_decode_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_i        (src_if),
    .dec_i        (dec_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beats_o      (beats),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("json_string_unescape_utf8 test failed");
    $finish;
  end

  function automatic bit is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_escape(logic [7:0] c);
    return c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL || c == jsu_pkg::CH_SLASH ||
           c == jsu_pkg::CH_B || c == jsu_pkg::CH_F || c == jsu_pkg::CH_N ||
           c == jsu_pkg::CH_R || c == jsu_pkg::CH_T || c == jsu_pkg::CH_U;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range('h20, 'h7E));
    while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 7))
      0:       return jsu_pkg::CH_QUOTE;
      1:       return jsu_pkg::CH_BSL;
      2:       return jsu_pkg::CH_SLASH;
      3:       return jsu_pkg::CH_B;
      4:       return jsu_pkg::CH_F;
      5:       return jsu_pkg::CH_N;
      6:       return jsu_pkg::CH_R;
      default: return jsu_pkg::CH_T;
    endcase
  endfunction

  function automatic logic [15:0] pick_code(int cls);
    bit edge_pick;
    bit hi_end;
    edge_pick = ($urandom_range(0, 4) == 0);
    hi_end    = $urandom_range(0, 1);
    case (cls)
      CP_ASCII: begin
        if (edge_pick) return hi_end ? 16'h007F : 16'h0000;
        return 16'($urandom_range('h0, 'h7F));
      end
      CP_TWO: begin
        if (edge_pick) return hi_end ? 16'h07FF : 16'h0080;
        return 16'($urandom_range('h80, 'h7FF));
      end
      CP_THREE: begin
        if (edge_pick) return hi_end ? 16'hFFFF : 16'h0800;
        if (hi_end) return 16'($urandom_range('hE000, 'hFFFF));
        return 16'($urandom_range('h800, 'hD7FF));
      end
      CP_HIGH: begin
        if (edge_pick) return hi_end ? jsu_pkg::HIGH_MAX : jsu_pkg::HIGH_MIN;
        return 16'($urandom_range(jsu_pkg::HIGH_MIN, jsu_pkg::HIGH_MAX));
      end
      default: begin
        if (edge_pick) return hi_end ? jsu_pkg::LOW_MAX : jsu_pkg::LOW_MIN;
        return 16'($urandom_range(jsu_pkg::LOW_MIN, jsu_pkg::LOW_MAX));
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    src_q.insert(src_q.size(), src_beat_t'{data_byte: b, at_end: 1'b0});
  endtask

  task automatic push_end();
    src_q.insert(src_q.size(), src_beat_t'{data_byte: 8'($urandom), at_end: 1'b1});
  endtask

  task automatic push_hex4(input logic [15:0] v);
    push_byte(jsu_pkg::CH_BSL);
    push_byte(jsu_pkg::CH_U);
    for (int k = 3; k >= 0; k--) push_byte(hex_char(v[k*4 +: 4]));
  endtask

  // \u plus up to three digits, then a non-hex byte or the end mark
  task automatic push_broken_hex(input bit with_end);
    logic [7:0] c;
    push_byte(jsu_pkg::CH_BSL);
    push_byte(jsu_pkg::CH_U);
    repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
    if (with_end) begin
      push_end();
    end else begin
      do c = 8'($urandom); while (is_hex(c));
      push_byte(c);
    end
  endtask

  task automatic push_bad_escape();
    logic [7:0] c;
    push_byte(jsu_pkg::CH_BSL);
    do c = 8'($urandom); while (is_escape(c));
    push_byte(c);
  endtask

  task automatic gen_string();
    strings++;
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1)) push_end();
      else push_byte(text_char());
    end
    push_byte(jsu_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 9: push_byte(text_char());
        3: push_byte(8'($urandom_range('h80, 'hFF)));
        4: begin
          push_byte(jsu_pkg::CH_BSL);
          push_byte(simple_escape());
        end
        5, 6: push_hex4(pick_code($urandom_range(CP_ASCII, CP_LOW)));
        7: begin
          push_hex4(pick_code(CP_HIGH));
          push_hex4(pick_code(CP_LOW));
        end
        default: begin
          push_hex4(pick_code(CP_HIGH));
          case ($urandom_range(0, 3))
            0: push_byte(text_char());
            1: begin
              push_byte(jsu_pkg::CH_BSL);
              push_byte(simple_escape());
            end
            2: push_hex4(pick_code($urandom_range(CP_ASCII, CP_LOW)));
            default: push_byte(8'($urandom_range('h80, 'hFF)));
          endcase
        end
      endcase
    end
    case ($urandom_range(0, 15))
      8: push_byte(8'($urandom_range(0, 'h1F)));
      9: push_bad_escape();
      10: push_broken_hex(1'b0);
      11: push_end();
      12: begin
        push_byte(jsu_pkg::CH_BSL);
        push_end();
      end
      13: push_broken_hex(1'b1);
      14: begin
        push_hex4(pick_code(CP_HIGH));
        case ($urandom_range(0, 4))
          0: push_end();
          1: begin
            push_byte(jsu_pkg::CH_BSL);
            push_end();
          end
          2: push_bad_escape();
          3: push_broken_hex(1'b0);
          default: push_broken_hex(1'b1);
        endcase
      end
      15: begin
        push_hex4(pick_code(CP_HIGH));
        case ($urandom_range(0, 2))
          0: push_byte(8'($urandom_range(0, 'h1F)));
          1: push_byte(jsu_pkg::CH_QUOTE);
          default: begin
            push_byte(jsu_pkg::CH_BSL);
            push_byte(simple_escape());
            push_byte(jsu_pkg::CH_QUOTE);
          end
        endcase
      end
      default: push_byte(jsu_pkg::CH_QUOTE);
    endcase
  endtask

  initial begin : sender
    int burst;
    int gap;
    src_if.valid     = 1'b0;
    src_if.data_byte = 8'h00;
    src_if.at_end    = 1'b0;

    // idle junk, idle end, then a string through extremes, a pair and errors
    push_byte("a");
    push_end();
    push_byte(jsu_pkg::CH_QUOTE);
    push_byte(8'hFF);
    push_byte(8'h20);
    push_byte(jsu_pkg::CH_BSL);
    push_byte(jsu_pkg::CH_T);
    push_hex4(16'hD83D);
    push_hex4(16'hDE00);
    push_byte(jsu_pkg::CH_QUOTE);
    push_byte(jsu_pkg::CH_QUOTE);
    push_byte(8'h1F);
    push_byte(jsu_pkg::CH_QUOTE);
    push_byte(jsu_pkg::CH_BSL);
    push_end();
    while (src_q.size() < 25 + RANDOM_BEATS) gen_string();

    wait (rst_ni);
    @(negedge clk_i);
    burst = 0;
    foreach (src_q[i]) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          src_if.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst--;
      src_if.valid     <= 1'b1;
      src_if.data_byte <= src_q[i].data_byte;
      src_if.at_end    <= src_q[i].at_end;
      do @(posedge clk_i); while (!src_if.ready);
      sent++;
      @(negedge clk_i);
    end
    src_if.valid <= 1'b0;
    src_done = 1'b1;
  end

  initial begin : receiver
    int  mode;
    int  tick;
    bit  held;
    dec_if.ready = 1'b0;
    tick = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(8, 64)) begin
        @(negedge clk_i);
        if (!held && sent >= HOLD_AT) begin
          // long hold-off so the command queue fills and in_i.ready drops
          dec_if.ready <= 1'b0;
          held = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk_i);
        end
        tick++;
        case (mode)
          0:       dec_if.ready <= 1'b1;
          1:       dec_if.ready <= ($urandom_range(0, 3) != 0);
          2:       dec_if.ready <= ($urandom_range(0, 3) == 0);
          default: dec_if.ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin : verdict
    wait (src_done);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d source beats across %0d generated strings; %0d result beats checked.",
             beats, strings, results);
    $display("Mix: escapes, \\u codes of every UTF-8 length, surrogate pairs and lone halves,");
    $display("     error endings, bursty sender, stalling receiver with a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("json_string_unescape_utf8 test passed");
    end else begin
      $display("json_string_unescape_utf8 test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/jsu_pkg.sv
src/jsu_in_if.sv
src/jsu_out_if.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8.sv
tb/jsu_decode_check.sv
tb/tb_json_string_unescape_utf8.sv
